/* sv/sap_pkg.sv */
// ----------------------------------------------------------------------------
// sap_pkg - shared types of the supervisor automaton player
// Item codes, payload widths and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package sap_pkg;

   localparam int FUNC_W   = 2;
   localparam int TADDR_W  = 12;
   localparam int BYTE_W   = 8;
   localparam int SIDX_W   = 3;
   localparam int MASK_W   = 64;
   localparam int STATE_W  = 16;
   localparam int EVENT_W  = 6;
   localparam int COUNT_W  = 7;

   // bytes per transition entry: event, next state high, next state low
   localparam int ENTRY_BYTES = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TABLE  = 2'd0,
      FUNC_RECORD = 2'd1,
      FUNC_RESET  = 2'd2,
      FUNC_APPLY  = 2'd3
   } func_type;

   typedef struct packed {
      logic accept;     // take the request payload
      logic ram_wr;     // write table byte at pos
      logic ram_rd;     // read table byte at pos
      logic sup_init;   // open the current supervisor, decide apply mode
      logic restart;    // rewalk current supervisor for the enable scan
      logic walk_step;  // skip one state record
      logic head_load;  // latch transition count
      logic scan_skip;  // step over one transition
      logic pos_inc;    // step over the event byte of a match
      logic hi_load;    // latch next-state high byte
      logic lo_load;    // commit next state
      logic sup_done;   // fold supervisor into enabled mask
      logic cnt_init;
      logic cnt_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      func_type new_func;
      logic     pos_ok;
      logic     walk_done;
      logic     scan_done;
      logic     apply;
      logic     match;
      logic     last_sup;
      logic     cnt_last;
      logic     rsp_free;
   } status_type;

endpackage

/* sv/sap_req_if.sv */
// ----------------------------------------------------------------------------
// sap_req_if - request channel
// valid/ready channel carrying one player item.
// ----------------------------------------------------------------------------
interface sap_req_if;
   logic                          valid;
   logic                          ready;
   logic [sap_pkg::FUNC_W-1:0]    func;
   logic [sap_pkg::TADDR_W-1:0]   table_address;
   logic [sap_pkg::BYTE_W-1:0]    table_byte;
   logic [sap_pkg::SIDX_W-1:0]    supervisor_index;
   logic [sap_pkg::MASK_W-1:0]    alphabet_mask;
   logic [sap_pkg::TADDR_W-1:0]   table_start;
   logic [sap_pkg::STATE_W-1:0]   initial_state;
   logic [sap_pkg::EVENT_W-1:0]   event_number;

   modport source (output valid, func, table_address, table_byte, supervisor_index,
                   alphabet_mask, table_start, initial_state, event_number,
                   input ready);
   modport sink   (input valid, func, table_address, table_byte, supervisor_index,
                   alphabet_mask, table_start, initial_state, event_number,
                   output ready);
endinterface

/* sv/sap_rsp_if.sv */
// ----------------------------------------------------------------------------
// sap_rsp_if - response channel
// valid/ready channel carrying the enabled event mask and its count.
// ----------------------------------------------------------------------------
interface sap_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sap_pkg::MASK_W-1:0]    enabled_mask;
   logic [sap_pkg::COUNT_W-1:0]   enabled_count;

   modport source (output valid, enabled_mask, enabled_count, input ready);
   modport sink   (input valid, enabled_mask, enabled_count, output ready);
endinterface

/* sv/sap_csr_if.sv */
// ----------------------------------------------------------------------------
// sap_csr_if - register write channel
// valid/ready channel carrying the controllable event mask.
// ----------------------------------------------------------------------------
interface sap_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sap_pkg::MASK_W-1:0]    data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* sv/sap_ram.sv */
// ----------------------------------------------------------------------------
// sap_ram - generic single port RAM
// One access per cycle, registered read data.
// ----------------------------------------------------------------------------
module sap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/sap_dp.sv */
// ----------------------------------------------------------------------------
// sap_dp - player datapath
// Supervisor records, table pointer with wrap, scan registers, result.
// ----------------------------------------------------------------------------
module sap_dp #(
   parameter int EVENT_COUNT      = 64,
   parameter int SUPERVISOR_COUNT = 8,
   parameter int TABLE_DEPTH      = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sap_pkg::FUNC_W-1:0]    req_func,
   input  logic [sap_pkg::TADDR_W-1:0]   req_table_address,
   input  logic [sap_pkg::BYTE_W-1:0]    req_table_byte,
   input  logic [sap_pkg::SIDX_W-1:0]    req_supervisor_index,
   input  logic [sap_pkg::MASK_W-1:0]    req_alphabet_mask,
   input  logic [sap_pkg::TADDR_W-1:0]   req_table_start,
   input  logic [sap_pkg::STATE_W-1:0]   req_initial_state,
   input  logic [sap_pkg::EVENT_W-1:0]   req_event_number,
   input  logic                          csr_valid,
   input  logic [sap_pkg::MASK_W-1:0]    csr_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [sap_pkg::MASK_W-1:0]    rsp_enabled_mask,
   output logic [sap_pkg::COUNT_W-1:0]   rsp_enabled_count,
   input  sap_pkg::cmd_type              cmd,
   output sap_pkg::status_type           status
);
   import sap_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int PW = $clog2(TABLE_DEPTH + 4096);
   localparam int SW = (SUPERVISOR_COUNT > 1) ? $clog2(SUPERVISOR_COUNT) : 1;
   localparam int IW = (SW > SIDX_W) ? SW : SIDX_W;
   localparam logic [MASK_W-1:0] EV_MASK = (EVENT_COUNT >= MASK_W) ? {MASK_W{1'b1}} :
                                           ((MASK_W'(1) << EVENT_COUNT) - MASK_W'(1));

   logic [MASK_W-1:0]  alpha_ff [SUPERVISOR_COUNT];
   logic [TADDR_W-1:0] start_ff [SUPERVISOR_COUNT];
   logic [STATE_W-1:0] init_ff  [SUPERVISOR_COUNT];
   logic [STATE_W-1:0] cur_ff   [SUPERVISOR_COUNT];

   logic [PW-1:0]      pos_ff, pos_in;
   logic [STATE_W-1:0] walk_ff;
   logic [BYTE_W-1:0]  n_ff, k_ff, byte_ff, hi_ff;
   logic [SW-1:0]      sup_ff;
   logic               apply_ff;
   func_type           func_ff;
   logic [EVENT_W-1:0] ev_ff, bit_ff;
   logic [MASK_W-1:0]  present_ff, en_ff, ctrl_ff, rsp_mask_ff;
   logic [COUNT_W-1:0] count_ff, rsp_count_ff;
   logic               rsp_valid_ff;

   logic [BYTE_W-1:0]  rdata;
   logic               pos_ok;
   logic [IW-1:0]      load_idx;

   assign pos_ok   = pos_ff < PW'(TABLE_DEPTH);
   assign load_idx = IW'(req_supervisor_index);

   sap_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (cmd.ram_wr),
      .rd_en   (cmd.ram_rd),
      .addr    (pos_ff[AW-1:0]),
      .wr_data (byte_ff),
      .rd_data (rdata)
   );

   // pointer: command updates win, otherwise fold back below the table depth
   always_comb begin
      pos_in = pos_ff;
      if (cmd.accept) begin
         pos_in = PW'(req_table_address);
      end else if (cmd.sup_init || cmd.restart) begin
         pos_in = PW'(start_ff[sup_ff]);
      end else if (cmd.walk_step) begin
         pos_in = pos_ff + PW'({rdata, 1'b0}) + PW'(rdata) + PW'(1);
      end else if (cmd.scan_skip) begin
         pos_in = pos_ff + PW'(ENTRY_BYTES);
      end else if (cmd.head_load || cmd.pos_inc || cmd.hi_load) begin
         pos_in = pos_ff + PW'(1);
      end else if (!pos_ok) begin
         pos_in = pos_ff - PW'(TABLE_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.accept) begin
         func_ff <= func_type'(req_func);
         ev_ff   <= req_event_number;
         byte_ff <= req_table_byte;
         en_ff   <= ctrl_ff & EV_MASK;
      end
      if (cmd.sup_init || cmd.restart) begin
         walk_ff    <= '0;
         present_ff <= '0;
      end
      if (cmd.walk_step) begin
         walk_ff <= walk_ff + STATE_W'(1);
      end
      if (cmd.head_load) begin
         n_ff <= rdata;
         k_ff <= '0;
      end
      if (cmd.scan_skip) begin
         k_ff <= k_ff + BYTE_W'(1);
         if (!apply_ff && rdata < BYTE_W'(EVENT_COUNT)) begin
            present_ff[rdata[EVENT_W-1:0]] <= 1'b1;
         end
      end
      if (cmd.hi_load) begin
         hi_ff <= rdata;
      end
      if (cmd.sup_done) begin
         en_ff <= en_ff & ~(alpha_ff[sup_ff] & EV_MASK & ~present_ff);
      end
      if (cmd.cnt_init) begin
         bit_ff   <= '0;
         count_ff <= '0;
      end
      if (cmd.cnt_step) begin
         bit_ff   <= bit_ff + EVENT_W'(1);
         count_ff <= count_ff + COUNT_W'(en_ff[bit_ff]);
      end
      if (cmd.rsp_load) begin
         rsp_mask_ff  <= en_ff;
         rsp_count_ff <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sup_ff       <= '0;
         apply_ff     <= 1'b0;
         ctrl_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SUPERVISOR_COUNT; i++) begin
            alpha_ff[i] <= '0;
            start_ff[i] <= '0;
            init_ff[i]  <= '0;
            cur_ff[i]   <= '0;
         end
      end else begin
         if (csr_valid) begin
            ctrl_ff <= csr_data;
         end
         if (cmd.accept) begin
            sup_ff <= '0;
            if (func_type'(req_func) == FUNC_RECORD
                && {1'b0, load_idx} < (IW + 1)'(SUPERVISOR_COUNT)) begin
               alpha_ff[load_idx[SW-1:0]] <= req_alphabet_mask;
               start_ff[load_idx[SW-1:0]] <= req_table_start;
               init_ff[load_idx[SW-1:0]]  <= req_initial_state;
            end
            if (func_type'(req_func) == FUNC_RESET) begin
               for (int i = 0; i < SUPERVISOR_COUNT; i++) begin
                  cur_ff[i] <= init_ff[i];
               end
            end
         end
         if (cmd.sup_init) begin
            apply_ff <= (func_ff == FUNC_APPLY)
                        && ({1'b0, ev_ff} < (EVENT_W + 1)'(EVENT_COUNT))
                        && alpha_ff[sup_ff][ev_ff];
         end else if (cmd.restart) begin
            apply_ff <= 1'b0;
         end
         if (cmd.lo_load) begin
            cur_ff[sup_ff] <= {hi_ff, rdata};
         end
         if (cmd.sup_done) begin
            sup_ff <= (sup_ff == SW'(SUPERVISOR_COUNT - 1)) ? '0 : sup_ff + SW'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.new_func  = func_type'(req_func);
      status.pos_ok    = pos_ok;
      status.walk_done = walk_ff == cur_ff[sup_ff];
      status.scan_done = k_ff == n_ff;
      status.apply     = apply_ff;
      status.match     = apply_ff && (rdata == BYTE_W'(ev_ff));
      status.last_sup  = sup_ff == SW'(SUPERVISOR_COUNT - 1);
      status.cnt_last  = bit_ff == EVENT_W'(MASK_W - 1);
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_enabled_mask  = rsp_mask_ff;
   assign rsp_enabled_count = rsp_count_ff;
endmodule

/* sv/sap_ctrl.sv */
// ----------------------------------------------------------------------------
// sap_ctrl - player controller
// Sequences table writes, state walks, transition scans and the bit count.
// ----------------------------------------------------------------------------
module sap_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sap_pkg::status_type  status,
   output sap_pkg::cmd_type     cmd
);
   import sap_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE       = 14'b00000000000001,
      ST_WRITE      = 14'b00000000000010,
      ST_SUP_INIT   = 14'b00000000000100,
      ST_WALK_ISSUE = 14'b00000000001000,
      ST_WALK_DATA  = 14'b00000000010000,
      ST_HEAD_DATA  = 14'b00000000100000,
      ST_SCAN_ISSUE = 14'b00000001000000,
      ST_SCAN_DATA  = 14'b00000010000000,
      ST_HI_ISSUE   = 14'b00000100000000,
      ST_HI_DATA    = 14'b00001000000000,
      ST_LO_ISSUE   = 14'b00010000000000,
      ST_LO_DATA    = 14'b00100000000000,
      ST_COUNT      = 14'b01000000000000,
      ST_FINISH     = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (status.new_func == FUNC_TABLE) ? ST_WRITE : ST_SUP_INIT;
            end
         end
         ST_WRITE: begin
            if (status.pos_ok) begin
               cmd.ram_wr = 1'b1;
               state_in   = ST_SUP_INIT;
            end
         end
         ST_SUP_INIT: begin
            cmd.sup_init = 1'b1;
            state_in     = ST_WALK_ISSUE;
         end
         ST_WALK_ISSUE: begin
            if (status.pos_ok) begin
               cmd.ram_rd = 1'b1;
               state_in   = status.walk_done ? ST_HEAD_DATA : ST_WALK_DATA;
            end
         end
         ST_WALK_DATA: begin
            cmd.walk_step = 1'b1;
            state_in      = ST_WALK_ISSUE;
         end
         ST_HEAD_DATA: begin
            cmd.head_load = 1'b1;
            state_in      = ST_SCAN_ISSUE;
         end
         ST_SCAN_ISSUE: begin
            if (status.pos_ok) begin
               if (!status.scan_done) begin
                  cmd.ram_rd = 1'b1;
                  state_in   = ST_SCAN_DATA;
               end else if (status.apply) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_WALK_ISSUE;
               end else begin
                  cmd.sup_done = 1'b1;
                  if (status.last_sup) begin
                     cmd.cnt_init = 1'b1;
                     state_in     = ST_COUNT;
                  end else begin
                     state_in = ST_SUP_INIT;
                  end
               end
            end
         end
         ST_SCAN_DATA: begin
            if (status.match) begin
               cmd.pos_inc = 1'b1;
               state_in    = ST_HI_ISSUE;
            end else begin
               cmd.scan_skip = 1'b1;
               state_in      = ST_SCAN_ISSUE;
            end
         end
         ST_HI_ISSUE: begin
            if (status.pos_ok) begin
               cmd.ram_rd = 1'b1;
               state_in   = ST_HI_DATA;
            end
         end
         ST_HI_DATA: begin
            cmd.hi_load = 1'b1;
            state_in    = ST_LO_ISSUE;
         end
         ST_LO_ISSUE: begin
            if (status.pos_ok) begin
               cmd.ram_rd = 1'b1;
               state_in   = ST_LO_DATA;
            end
         end
         ST_LO_DATA: begin
            cmd.lo_load = 1'b1;
            cmd.restart = 1'b1;
            state_in    = ST_WALK_ISSUE;
         end
         ST_COUNT: begin
            cmd.cnt_step = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* sv/supervisor_automaton_player.sv */
// ----------------------------------------------------------------------------
// supervisor_automaton_player - top level
// Runs supervisor automata held in a compressed byte table and reports the
// controllable events that every supervisor allows.
// ----------------------------------------------------------------------------
//  channel   dir  handshake    payload
//  req_chan  in   valid/ready  func, table/record/event fields
//  rsp_chan  out  valid/ready  enabled_mask, enabled_count
//  csr_chan  in   valid/ready  controllable mask (always ready)
//
//  One item at a time. Per item: an accept step (plus a write step for a table
//  write), then per supervisor an open step, an issue and a data step per
//  skipped state record and per transition, a read of the count byte and a
//  close step; a supervisor whose alphabet holds the applied event is walked
//  twice, reading the next-state bytes to take a matching transition. A pointer
//  past the table top is folded back before use. Then the mask is counted bit by
//  bit and the response loaded. The single table RAM port sets the pace.
//  Reset (synchronous) zeroes records, states and the mask; the table
//  itself is not cleared. A held response stalls only the finish step.
// ----------------------------------------------------------------------------
module supervisor_automaton_player #(
   parameter int EVENT_COUNT      = 64,
   parameter int SUPERVISOR_COUNT = 8,
   parameter int TABLE_DEPTH      = 4096
) (
   input logic      clock,
   input logic      reset,
   sap_req_if.sink  req_chan,
   sap_rsp_if.source rsp_chan,
   sap_csr_if.sink  csr_chan
);
   import sap_pkg::*;

   cmd_type    cmd;
   status_type status;

   // register writes must arrive only while idle, which the block does not enforce; the port never pushes back
   assign csr_chan.ready = 1'b1;

   sap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sap_dp #(
      .EVENT_COUNT      (EVENT_COUNT),
      .SUPERVISOR_COUNT (SUPERVISOR_COUNT),
      .TABLE_DEPTH      (TABLE_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_func             (req_chan.func),
      .req_table_address    (req_chan.table_address),
      .req_table_byte       (req_chan.table_byte),
      .req_supervisor_index (req_chan.supervisor_index),
      .req_alphabet_mask    (req_chan.alphabet_mask),
      .req_table_start      (req_chan.table_start),
      .req_initial_state    (req_chan.initial_state),
      .req_event_number     (req_chan.event_number),
      .csr_valid            (csr_chan.valid),
      .csr_data             (csr_chan.data),
      .rsp_ready            (rsp_chan.ready),
      .rsp_valid            (rsp_chan.valid),
      .rsp_enabled_mask     (rsp_chan.enabled_mask),
      .rsp_enabled_count    (rsp_chan.enabled_count),
      .cmd                  (cmd),
      .status               (status)
   );
endmodule

/* dv/tb_supervisor_automaton_player.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_supervisor_automaton_player - testbench of the supervisor automaton player
// Loads small random automata into the byte table, drives events through them
// and checks every enabled mask and count against a predictor kept in step
// with each request transfer.
// ----------------------------------------------------------------------------
module tb_supervisor_automaton_player;
   import sap_pkg::*;

   localparam int SUPS       = 8;
   localparam int DEPTH      = 4096;
   localparam int SUP_STATES = 4;
   // each random phase owns 512 bytes from here, 64 per supervisor
   localparam logic [TADDR_W-1:0] REGION_BASE = 12'h100;
   // table writes that no walk ever reaches
   localparam logic [TADDR_W-1:0] NOISE_BASE  = 12'h900;
   // first record of the looping chain used by the long walk
   localparam logic [TADDR_W-1:0] LOOP_BASE   = 12'hC00;

   typedef struct {
      func_type             func;
      logic [TADDR_W-1:0]   table_address;
      logic [BYTE_W-1:0]    table_byte;
      logic [SIDX_W-1:0]    supervisor_index;
      logic [MASK_W-1:0]    alphabet_mask;
      logic [TADDR_W-1:0]   table_start;
      logic [STATE_W-1:0]   initial_state;
      logic [EVENT_W-1:0]   event_number;
   } player_item_type;

   typedef struct {
      logic [MASK_W-1:0]  mask;
      logic [COUNT_W-1:0] count;
   } enabled_type;

   logic clock;
   logic reset;

   sap_req_if req_if ();
   sap_rsp_if rsp_if ();
   sap_csr_if csr_if ();

   supervisor_automaton_player i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .csr_chan (csr_if.sink)
   );

   // predictor copy of the block's state
   logic [BYTE_W-1:0]  tbl       [DEPTH];
   logic [TADDR_W-1:0] sup_start [SUPS];
   logic [STATE_W-1:0] sup_init  [SUPS];
   logic [STATE_W-1:0] sup_state [SUPS];
   logic [MASK_W-1:0]  sup_alpha [SUPS];
   logic [MASK_W-1:0]  ctl_mask;

   // the phase's event pool
   logic [EVENT_W-1:0] ev_pool [8];

   enabled_type pending_masks [$];
   int          mismatches;
   int          items_sent;
   int          results_seen;
   int          applies_sent;

   // sender burst shaping
   int burst_left;

   // ---------------------------------------------------------------- clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous ceiling on simulated time for the whole run
   initial begin
      #(200_000_000);
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   // count byte address of a supervisor's current state: skip one record per state
   function automatic logic [TADDR_W-1:0] state_pos(int s);
      logic [TADDR_W-1:0] pos;
      pos = sup_start[s];
      for (int k = 0; k < sup_state[s]; k++)
         pos = pos + TADDR_W'(tbl[pos] * ENTRY_BYTES + 1);
      return pos;
   endfunction

   function automatic void step_event(logic [EVENT_W-1:0] ev);
      logic [TADDR_W-1:0] pos;
      int n;
      for (int s = 0; s < SUPS; s++) begin
         if (sup_alpha[s][ev]) begin
            pos = state_pos(s);
            n   = tbl[pos];
            pos = pos + TADDR_W'(1);
            for (int k = 0; k < n; k++) begin
               if (tbl[pos] == BYTE_W'(ev)) begin
                  sup_state[s] = {tbl[pos + 12'd1], tbl[pos + 12'd2]};
                  break;
               end
               pos = pos + TADDR_W'(ENTRY_BYTES);
            end
         end
      end
   endfunction

   function automatic enabled_type enabled_after();
      enabled_type        r;
      logic [MASK_W-1:0]  present;
      logic [TADDR_W-1:0] pos;
      int n;
      r.mask = ctl_mask;
      for (int s = 0; s < SUPS; s++) begin
         present = '0;
         pos = state_pos(s);
         n   = tbl[pos];
         pos = pos + TADDR_W'(1);
         for (int k = 0; k < n; k++) begin
            // event bytes of 64 and above enable nothing
            if (tbl[pos] < MASK_W)
               present[tbl[pos][EVENT_W-1:0]] = 1'b1;
            pos = pos + TADDR_W'(ENTRY_BYTES);
         end
         r.mask &= ~(sup_alpha[s] & ~present);
      end
      r.count = COUNT_W'($countones(r.mask));
      return r;
   endfunction

   function automatic void predict(player_item_type it);
      case (it.func)
         FUNC_TABLE: begin
            tbl[it.table_address] = it.table_byte;
         end
         FUNC_RECORD: begin
            // current state is left alone until the next reset of states
            sup_alpha[it.supervisor_index] = it.alphabet_mask;
            sup_start[it.supervisor_index] = it.table_start;
            sup_init[it.supervisor_index]  = it.initial_state;
         end
         FUNC_RESET: begin
            for (int s = 0; s < SUPS; s++)
               sup_state[s] = sup_init[s];
         end
         default: begin
            step_event(it.event_number);
         end
      endcase
      pending_masks.push_back(enabled_after());
   endfunction

   // ---------------------------------------------------------------- driving
   function automatic player_item_type noise_item(func_type f);
      player_item_type it;
      it.func             = f;
      it.table_address    = TADDR_W'($urandom);
      it.table_byte       = BYTE_W'($urandom);
      it.supervisor_index = SIDX_W'($urandom);
      it.alphabet_mask    = {$urandom, $urandom};
      it.table_start      = TADDR_W'($urandom);
      it.initial_state    = STATE_W'($urandom);
      it.event_number     = EVENT_W'($urandom);
      return it;
   endfunction

   // one request transfer; bursts of random length with random gaps
   task automatic send_item(player_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_if.valid            <= 1'b1;
      req_if.func             <= it.func;
      req_if.table_address    <= it.table_address;
      req_if.table_byte       <= it.table_byte;
      req_if.supervisor_index <= it.supervisor_index;
      req_if.alphabet_mask    <= it.alphabet_mask;
      req_if.table_start      <= it.table_start;
      req_if.initial_state    <= it.initial_state;
      req_if.event_number     <= it.event_number;
      do @(posedge clock); while (!req_if.ready);
      predict(it);
      burst_left--;
      items_sent++;
      if (it.func == FUNC_APPLY)
         applies_sent++;
   endtask

   task automatic write_byte(logic [TADDR_W-1:0] a, logic [BYTE_W-1:0] b);
      player_item_type it;
      it = noise_item(FUNC_TABLE);
      it.table_address = a;
      it.table_byte    = b;
      send_item(it);
   endtask

   task automatic load_record(int s, logic [MASK_W-1:0] alpha, logic [TADDR_W-1:0] start,
                              logic [STATE_W-1:0] init);
      player_item_type it;
      it = noise_item(FUNC_RECORD);
      it.supervisor_index = SIDX_W'(s);
      it.alphabet_mask    = alpha;
      it.table_start      = start;
      it.initial_state    = init;
      send_item(it);
   endtask

   task automatic apply_ev(logic [EVENT_W-1:0] ev);
      player_item_type it;
      it = noise_item(FUNC_APPLY);
      it.event_number = ev;
      send_item(it);
   endtask

   task automatic reset_states();
      send_item(noise_item(FUNC_RESET));
   endtask

   // wait for every outstanding transfer, then let the block settle
   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending_masks.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // register write, only ever issued while the block is idle
   task automatic write_ctl(logic [MASK_W-1:0] v);
      drain();
      csr_if.valid <= 1'b1;
      csr_if.data  <= v;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      ctl_mask = v;
   endtask

   // ---------------------------------------------------------------- checking
   int stall_left;
   bit stall_mode;

   always @(posedge clock) begin
      enabled_type exp_r;
      // receiver alternates between always-ready stretches and random stalls
      if (stall_left == 0) begin
         stall_mode = ($urandom_range(0, 2) != 0);
         stall_left = $urandom_range(5, 60);
      end else begin
         stall_left--;
      end
      rsp_if.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;

      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (pending_masks.size() == 0) begin
            $error("enabled_mask result with nothing outstanding: %h", rsp_if.enabled_mask);
            mismatches++;
         end else begin
            exp_r = pending_masks.pop_front();
            if (rsp_if.enabled_mask !== exp_r.mask) begin
               $error("enabled_mask expected %h actual %h", exp_r.mask, rsp_if.enabled_mask);
               mismatches++;
            end
            if (rsp_if.enabled_count !== exp_r.count) begin
               $error("enabled_count expected %0d actual %0d", exp_r.count,
                      rsp_if.enabled_count);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests
   // Every supervisor reads address 0 after reset: an empty state goes there.
   task automatic test_table_fill();
      write_byte(12'h000, 8'h00);
   endtask

   // Highest initial state: ten records whose lengths add up to the table
   // size, so the walk goes round the table once every ten states. The
   // records reached by state 0 and by state 65535 are empty.
   task automatic test_long_walk();
      logic [BYTE_W-1:0]  cnt [10];
      logic [TADDR_W-1:0] pos;
      cnt = '{8'd0, 8'd170, 8'd170, 8'd170, 8'd171, 8'd0, 8'd170, 8'd170, 8'd170, 8'd171};
      write_ctl('1);
      pos = LOOP_BASE;
      for (int k = 0; k < 10; k++) begin
         write_byte(pos, cnt[k]);
         pos = pos + TADDR_W'(cnt[k] * ENTRY_BYTES + 1);
      end
      load_record(7, '1, LOOP_BASE, 16'hFFFF);
      reset_states();
      apply_ev(6'd63);
      load_record(7, '0, LOOP_BASE, 16'h0000);
      reset_states();
   endtask

   // Hand-built automaton straddling the top of the table, with an event byte
   // out of range, an event absent from the alphabet, and a record reload
   // that must not move the current state.
   task automatic test_directed();
      logic [BYTE_W-1:0] img [11];
      img = '{8'd2, 8'd5, 8'd0, 8'd1, 8'd200, 8'd0, 8'd0, 8'd1, 8'd5, 8'd0, 8'd0};
      for (int k = 0; k < 11; k++)
         write_byte(12'hFFE + TADDR_W'(k), img[k]);
      load_record(0, (64'd1 << 5) | (64'd1 << 9), 12'hFFE, 16'd0);
      reset_states();
      apply_ev(6'd5);
      apply_ev(6'd9);
      load_record(0, (64'd1 << 5) | (64'd1 << 9) | (64'd1 << 63), 12'hFFE, 16'd1);
      apply_ev(6'd5);
      apply_ev(6'd0);
      reset_states();
      apply_ev(6'd63);
      apply_ev(6'd5);
      load_record(0, '0, 12'h000, 16'd0);
      reset_states();
   endtask

   function automatic logic [MASK_W-1:0] random_alphabet();
      logic [MASK_W-1:0] m;
      m = '0;
      for (int k = 0; k < 8; k++)
         if ($urandom_range(0, 1)) m[ev_pool[k]] = 1'b1;
      if ($urandom_range(0, 3) == 0)
         m |= {$urandom, $urandom} & {$urandom, $urandom};
      return m;
   endfunction

   function automatic logic [EVENT_W-1:0] pick_event();
      return ($urandom_range(0, 4) != 0) ? ev_pool[$urandom_range(0, 7)]
                                         : EVENT_W'($urandom);
   endfunction

   // random automaton: 4 states of up to 2 transitions, all in its region;
   // a fixed state count keeps any state carried over from an earlier phase valid
   task automatic build_automaton(logic [TADDR_W-1:0] base);
      logic [TADDR_W-1:0] pos;
      int n;
      pos = base;
      for (int st = 0; st < SUP_STATES; st++) begin
         n = $urandom_range(0, 2);
         write_byte(pos, BYTE_W'(n));
         pos++;
         for (int k = 0; k < n; k++) begin
            write_byte(pos, ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom_range(64, 255))
                                                        : BYTE_W'(pick_event()));
            write_byte(pos + 12'd1, 8'h00);
            write_byte(pos + 12'd2, BYTE_W'($urandom_range(0, SUP_STATES - 1)));
            pos = pos + TADDR_W'(ENTRY_BYTES);
         end
      end
   endtask

   task automatic test_random_phase(logic [MASK_W-1:0] ctl, int steps, int phase);
      int s;
      int pick;
      logic [TADDR_W-1:0] base;
      player_item_type it;
      base = REGION_BASE + TADDR_W'(phase * 512);
      write_ctl(ctl);
      for (int k = 0; k < 8; k++)
         ev_pool[k] = EVENT_W'($urandom);
      for (s = 0; s < SUPS; s++)
         build_automaton(base + TADDR_W'(s * 64));
      for (s = 0; s < SUPS; s++)
         load_record(s, random_alphabet(), base + TADDR_W'(s * 64),
                     STATE_W'($urandom_range(0, SUP_STATES - 1)));
      reset_states();
      for (int k = 0; k < steps; k++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            apply_ev(pick_event());
         end else if (pick == 7) begin
            it = noise_item(FUNC_TABLE);
            it.table_address = NOISE_BASE + TADDR_W'($urandom_range(0, 255));
            send_item(it);
         end else if (pick == 8) begin
            s = $urandom_range(0, SUPS - 1);
            load_record(s, random_alphabet(), base + TADDR_W'(s * 64),
                        STATE_W'($urandom_range(0, SUP_STATES - 1)));
         end else begin
            reset_states();
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      mismatches   = 0;
      items_sent   = 0;
      results_seen = 0;
      applies_sent = 0;
      burst_left   = 0;
      stall_left   = 0;
      stall_mode   = 1'b0;

      req_if.valid            = 1'b0;
      req_if.func             = FUNC_TABLE;
      req_if.table_address    = '0;
      req_if.table_byte       = '0;
      req_if.supervisor_index = '0;
      req_if.alphabet_mask    = '0;
      req_if.table_start      = '0;
      req_if.initial_state    = '0;
      req_if.event_number     = '0;
      rsp_if.ready            = 1'b0;
      csr_if.valid            = 1'b0;
      csr_if.data             = '0;

      for (int a = 0; a < DEPTH; a++)
         tbl[a] = '0;
      for (int s = 0; s < SUPS; s++) begin
         sup_start[s] = '0;
         sup_init[s]  = '0;
         sup_state[s] = '0;
         sup_alpha[s] = '0;
      end
      ctl_mask = '0;

      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_fill();
      test_long_walk();
      test_directed();
      test_random_phase({$urandom, $urandom}, 50, 0);
      test_random_phase('1, 50, 1);
      test_random_phase({$urandom, $urandom}, 50, 2);

      drain();
      repeat (300) @(posedge clock);
      if (pending_masks.size() != 0) begin
         $error("%0d enabled_mask results never arrived", pending_masks.size());
         mismatches++;
      end

      $display("Covered %0d request transfers (%0d events applied), %0d results checked,",
               items_sent, applies_sent, results_seen);
      $display("including a 65535-state walk round the table and automata wrapping its top.");
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
